>>> design/lpg_pkg.sv
package lpg_pkg;

    localparam int PIX_W = 6;

    typedef logic [PIX_W-1:0] pix_coord_t;

    typedef struct packed {
        pix_coord_t start_x;
        pix_coord_t start_y;
        pix_coord_t end_x;
        pix_coord_t end_y;
    } line_req_t;

    typedef struct packed {
        pix_coord_t pixel_x;
        pix_coord_t pixel_y;
        logic       last_pixel;
    } pixel_t;

    typedef struct packed {
        logic load;   // capture request endpoints
        logic setup;  // compute deltas, error term, run length
        logic step;   // advance to next pixel
    } lpg_cmd_t;

    typedef struct packed {
        logic zero_len;  // start equals end
        logic last;      // current pixel ends the run
    } lpg_status_t;

endpackage

>>> design/lpg_ctrl.sv
module lpg_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  lpg_pkg::lpg_status_t status,
    output lpg_pkg::lpg_cmd_t    cmd
);
    import lpg_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SETUP = 3'b010,
        ST_RUN   = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = status.zero_len ? ST_IDLE : ST_RUN;
            end
            ST_RUN: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    cmd.step = 1'b1;
                    if (status.last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and output handshakes open together");

    a_step_on_handshake: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> (m_valid && m_ready))
        else $error("pixel advanced without an accepted word");

    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && status.last) |=> s_ready)
        else $error("run did not end after last pixel");

    a_setup_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.setup |=> !cmd.setup)
        else $error("setup lasted more than one cycle");

    a_load_then_setup: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> cmd.setup)
        else $error("accepted request not set up");

endmodule

>>> design/lpg_datapath.sv
module lpg_datapath #(
    parameter int COORD_BITS = 6
) (
    input  logic                 aclk,
    input  lpg_pkg::line_req_t   s_data,
    input  lpg_pkg::lpg_cmd_t    cmd,
    output lpg_pkg::lpg_status_t status,
    output lpg_pkg::pixel_t      m_data
);
    import lpg_pkg::*;

    localparam int C = COORD_BITS;
    localparam int E = COORD_BITS + 3;

    logic [C-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic [C-1:0] maj_reg, mnr_reg, count_reg;
    logic signed [E-1:0] err_reg, two_min_reg, two_diff_reg;
    logic         steep_reg, maj_neg_reg, min_neg_reg;

    logic signed [C:0] dx, dy;
    logic [C-1:0] adx, ady, amaj, amin, maj0, mnr0;
    logic         steep, maj_neg, min_neg;
    logic signed [E-1:0] two_min, two_diff, err0;
    logic         err_pos;

    always_comb begin
        dx      = $signed({1'b0, ex_reg}) - $signed({1'b0, sx_reg});
        dy      = $signed({1'b0, ey_reg}) - $signed({1'b0, sy_reg});
        adx     = dx[C] ? C'(-dx) : C'(dx);
        ady     = dy[C] ? C'(-dy) : C'(dy);
        steep   = (ady >= adx);
        amaj    = steep ? ady : adx;
        amin    = steep ? adx : ady;
        maj_neg = steep ? dy[C] : dx[C];
        min_neg = steep ? dx[C] : dy[C];
        maj0    = steep ? sy_reg : sx_reg;
        mnr0    = steep ? sx_reg : sy_reg;
        two_min  = $signed(E'({amin, 1'b0}));
        two_diff = two_min - $signed(E'({amaj, 1'b0}));
        err0     = two_min - $signed(E'(amaj));
        err_pos  = !err_reg[E-1] && (err_reg != '0);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sx_reg <= s_data.start_x[C-1:0];
            sy_reg <= s_data.start_y[C-1:0];
            ex_reg <= s_data.end_x[C-1:0];
            ey_reg <= s_data.end_y[C-1:0];
        end
        if (cmd.setup) begin
            steep_reg    <= steep;
            maj_neg_reg  <= maj_neg;
            min_neg_reg  <= min_neg;
            two_min_reg  <= two_min;
            two_diff_reg <= two_diff;
            err_reg      <= err0;
            maj_reg      <= maj0;
            mnr_reg      <= mnr0;
            count_reg    <= amaj;
        end else if (cmd.step) begin
            // error positive: diagonal step, otherwise straight along major axis
            if (err_pos) begin
                err_reg <= err_reg + two_diff_reg;
                mnr_reg <= min_neg_reg ? mnr_reg - 1'b1 : mnr_reg + 1'b1;
            end else begin
                err_reg <= err_reg + two_min_reg;
            end
            maj_reg   <= maj_neg_reg ? maj_reg - 1'b1 : maj_reg + 1'b1;
            count_reg <= count_reg - 1'b1;
        end
    end

    always_comb begin
        status.zero_len   = (adx == '0) && (ady == '0);
        status.last       = (count_reg == C'(1));
        m_data.pixel_x    = pix_coord_t'(steep_reg ? mnr_reg : maj_reg);
        m_data.pixel_y    = pix_coord_t'(steep_reg ? maj_reg : mnr_reg);
        m_data.last_pixel = status.last;
    end

endmodule

>>> design/line_pixel_generator.sv
// Bresenham line rasterizer. Each accepted word on s_ is a line request
// (start and end point); the block returns its pixel run on m_, one word per
// pixel in drawing order, with last_pixel set on the final one. The end point
// itself is not drawn and a zero-length line returns nothing. Lines with
// |dy| >= |dx| walk along the row axis. Only the low COORD_BITS bits of each
// coordinate are used. A request is accepted, then set up, and then its pixels
// go out one per cycle while m_ready is high; a run has max(|dx|,|dy|) pixels,
// at most 2**COORD_BITS - 1. The single error/step datapath handles one
// request at a time and the next request is taken once the last pixel word
// has been accepted.
module line_pixel_generator #(
    parameter int COORD_BITS = 6
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  lpg_pkg::line_req_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output lpg_pkg::pixel_t    m_data
);
    import lpg_pkg::*;

    lpg_cmd_t    cmd;
    lpg_status_t status;

    lpg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    lpg_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .aclk   (aclk),
        .s_data (s_data),
        .cmd    (cmd),
        .status (status),
        .m_data (m_data)
    );

endmodule
